FILE: hw/rtl/xcfd_pkg.sv
// Shared types and constants of the frame deframer.
package xcfd_pkg;

	// Frame geometry.
	localparam int unsigned FRAME_MAX = 17;
	localparam int unsigned IDX_W     = 5;
	localparam int unsigned TIMER_W   = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// Prefix and header constants.
	localparam logic [7:0] PREFIX_LEAD  = 8'hFF;
	localparam logic [7:0] PREFIX_TAIL0 = 8'hFE;
	localparam logic [7:0] PREFIX_TAIL1 = 8'hFD;
	localparam logic [3:0] LEN_BIAS     = 4'd2;
	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd300;

	// Input word codes.
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREFIXED_MODE = 1'b0,
		REG_IDLE_TIMEOUT  = 1'b1
	} cfg_reg_t;

	// Synchronization phase of the prefix search.
	typedef enum logic [1:0] {
		PH_SEARCH  = 2'd0,
		PH_SAW_FF  = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	// Controller states.
	typedef enum logic {
		CT_IDLE = 1'b0,
		CT_EMIT = 1'b1
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_accept;
		logic out_accept;
	} xcfd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_ok;
		logic emit_last;
	} xcfd_status_t;

endpackage

FILE: hw/rtl/xcfd_if.sv
// Handshake channels for received words and for checked frame bytes.
interface xcfd_in_if;
	import xcfd_pkg::*;

	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface xcfd_out_if;
	import xcfd_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       last;

	modport source (output valid, output msg_byte, output last, input ready);
	modport sink (input valid, input msg_byte, input last, output ready);
endinterface

FILE: hw/rtl/xcfd_ctrl.sv
// Controller state machine: takes words while idle and drains a checked frame.
module xcfd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  xcfd_pkg::xcfd_status_t status,
	output xcfd_pkg::xcfd_cmd_t    cmd
);
	import xcfd_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd.in_accept  = 1'b0;
		cmd.out_accept = 1'b0;
		unique case (state_q)
			CT_IDLE: begin
				in_ready      = 1'b1;
				cmd.in_accept = in_valid;
				if (in_valid && status.frame_ok) begin
					state_d = CT_EMIT;
				end
			end
			CT_EMIT: begin
				out_valid      = 1'b1;
				cmd.out_accept = out_ready;
				if (out_ready && status.emit_last) begin
					state_d = CT_IDLE;
				end
			end
			default: begin
				state_d = CT_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/xcfd_dp.sv
// Datapath: configuration, frame store, prefix search, check and byte output.
module xcfd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [xcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [xcfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              op,
	input  logic [7:0]                        rx_byte,
	output logic [7:0]                        msg_byte,
	output logic                              last,
	input  xcfd_pkg::xcfd_cmd_t               cmd,
	output xcfd_pkg::xcfd_status_t            status
);
	import xcfd_pkg::*;

	// Configuration registers.
	logic               prefixed_q;
	logic [TIMER_W-1:0] timeout_q;

	// Frame state.
	logic [7:0]         store_q [FRAME_MAX];
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   len_q;
	logic [7:0]         xor_q;
	phase_t             phase_q;
	logic [TIMER_W-1:0] idle_q;
	logic [IDX_W-1:0]   emit_len_q;
	logic [IDX_W-1:0]   rd_idx_q;

	// Byte processing terms.
	logic               byte_en;
	logic               tick_en;
	logic               timeout_hit;
	logic [IDX_W-1:0]   base_cnt;
	logic [IDX_W-1:0]   base_len;
	logic [7:0]         base_xor;
	phase_t             base_phase;
	logic               do_collect;
	logic [7:0]         new_xor;
	logic [IDX_W-1:0]   new_cnt;
	logic [IDX_W-1:0]   new_len;
	logic               frame_done;
	logic               is_tail;
	logic [IDX_W-1:0]   rd_next;

	assign byte_en = cmd.in_accept && (op_t'(op) == OP_BYTE);
	assign tick_en = cmd.in_accept && (op_t'(op) == OP_TICK);

	// A stale partial frame or prefix is dropped when the link was idle too long.
	assign timeout_hit = (idle_q >= timeout_q) && ((cnt_q != '0) || (phase_q != PH_SEARCH));
	assign base_cnt    = timeout_hit ? '0 : cnt_q;
	assign base_len    = timeout_hit ? '0 : len_q;
	assign base_xor    = timeout_hit ? 8'h00 : xor_q;
	assign base_phase  = timeout_hit ? PH_SEARCH : phase_q;
	assign do_collect  = !prefixed_q || (base_phase == PH_COLLECT);

	// Collection: running check, count and length from the header nibble.
	assign new_xor    = base_xor ^ rx_byte;
	assign new_cnt    = base_cnt + IDX_W'(1);
	assign new_len    = (base_cnt == '0) ? (IDX_W'(rx_byte[3:0]) + IDX_W'(LEN_BIAS)) : base_len;
	assign frame_done = new_cnt >= new_len;
	assign is_tail    = (rx_byte == PREFIX_TAIL0) || (rx_byte == PREFIX_TAIL1);

	assign status.frame_ok = byte_en && do_collect && frame_done && (new_xor == 8'h00);

	// Output side reads the store at the drain pointer.
	assign rd_next          = rd_idx_q + IDX_W'(1);
	assign status.emit_last = (rd_next == emit_len_q);
	assign msg_byte         = store_q[rd_idx_q];
	assign last             = status.emit_last;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefixed_q <= 1'b0;
			timeout_q  <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PREFIXED_MODE: prefixed_q <= cfg_data[0];
				REG_IDLE_TIMEOUT:  timeout_q  <= cfg_data[TIMER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Frame store write; contents need no reset.
	always_ff @(posedge clk) begin
		if (byte_en && do_collect) begin
			store_q[base_cnt] <= rx_byte;
		end
	end

	// Idle timer: counts ticks, saturates, clears on every byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
		end else if (byte_en) begin
			idle_q <= '0;
		end else if (tick_en && (idle_q != TIMER_MAX)) begin
			idle_q <= idle_q + TIMER_W'(1);
		end
	end

	// Frame tracking and prefix search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			len_q      <= '0;
			xor_q      <= 8'h00;
			phase_q    <= PH_SEARCH;
			emit_len_q <= '0;
		end else if (byte_en) begin
			if (do_collect) begin
				if (frame_done) begin
					cnt_q      <= '0;
					len_q      <= '0;
					xor_q      <= 8'h00;
					phase_q    <= PH_SEARCH;
					emit_len_q <= new_len;
				end else begin
					cnt_q   <= new_cnt;
					len_q   <= new_len;
					xor_q   <= new_xor;
					phase_q <= base_phase;
				end
			end else if ((base_phase == PH_SAW_FF) && is_tail) begin
				// A complete prefix starts a fresh frame.
				cnt_q   <= '0;
				len_q   <= '0;
				xor_q   <= 8'h00;
				phase_q <= PH_COLLECT;
			end else begin
				// A lead byte is kept, anything else returns to searching.
				cnt_q   <= base_cnt;
				len_q   <= base_len;
				xor_q   <= base_xor;
				phase_q <= (rx_byte == PREFIX_LEAD) ? PH_SAW_FF : PH_SEARCH;
			end
		end
	end

	// Drain pointer over the checked frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.out_accept) begin
			rd_idx_q <= status.emit_last ? '0 : rd_next;
		end
	end

endmodule

FILE: hw/rtl/xor_checked_frame_deframer_top.sv
// Length-nibble, XOR-checked frame deframer: sequencer plus frame datapath.
// A good frame's header byte is on the output in the cycle after its check byte is taken.
// Throughput: one input word per cycle while idle; a good frame of n bytes then
// drains one byte per cycle while the output is ready; no input word is taken meanwhile.
// Reset: arst_n clears all control state, the mode register to plain framing and
// the idle timeout to 300 ticks; the frame store contents are left as they are.
module xor_checked_frame_deframer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [xcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xcfd_pkg::CFG_DATA_W-1:0] cfg_data,
	xcfd_in_if.sink                         rx_ch,
	xcfd_out_if.source                      tx_ch
);
	import xcfd_pkg::*;

	xcfd_cmd_t    cmd;
	xcfd_status_t status;

	// Sequencer.
	xcfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_ch.valid),
		.in_ready  (rx_ch.ready),
		.out_valid (tx_ch.valid),
		.out_ready (tx_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Frame datapath.
	xcfd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op        (rx_ch.op),
		.rx_byte   (rx_ch.rx_byte),
		.msg_byte  (tx_ch.msg_byte),
		.last      (tx_ch.last),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
